>>> rtl/core/tsdt_pkg.sv
// Package: shared types and constants of the touch stick deadzone tracker.
package tsdt_pkg;

    localparam int ALU_AW = 56;
    localparam int ALU_BW = 34;
    localparam int ALU_RW = 68;
    localparam int DIV_STEPS = 18;
    localparam int SQRT_STEPS = 28;
    localparam logic [ALU_AW-1:0] SQRT_BIT0 = 56'h40000000000000;

    localparam logic [1:0] ALU_MUL  = 2'd0;
    localparam logic [1:0] ALU_DIV  = 2'd1;
    localparam logic [1:0] ALU_SQRT = 2'd2;

    localparam logic [1:0] EV_PRESS   = 2'd0;
    localparam logic [1:0] EV_RELEASE = 2'd1;
    localparam logic [1:0] EV_DRAG    = 2'd2;

    localparam logic [1:0] MODE_DYNAMIC = 2'd1;
    localparam logic [1:0] MODE_FOLLOW  = 2'd2;

    localparam logic [3:0] CFG_MODE   = 4'd0;
    localparam logic [3:0] CFG_DIAM   = 4'd1;
    localparam logic [3:0] CFG_DEAD   = 4'd2;
    localparam logic [3:0] CFG_CLAMP  = 4'd3;
    localparam logic [3:0] CFG_REST_X = 4'd4;
    localparam logic [3:0] CFG_REST_Y = 4'd5;
    localparam logic [3:0] CFG_AREA_W = 4'd6;
    localparam logic [3:0] CFG_AREA_H = 4'd7;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

endpackage

>>> rtl/core/tsdt_alu.sv
// Shared arithmetic unit: multiply, rounded divide and integer square root.
module tsdt_alu import tsdt_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_alu_req                 i_req,
    input  logic [ALU_AW-1:0]        i_a,
    input  logic signed [ALU_BW-1:0] i_b,
    output t_alu_rsp                 o_rsp,
    output logic signed [ALU_RW-1:0] o_res
);

    logic                     r_busy;
    logic                     r_done;
    logic [1:0]               r_op;
    logic [4:0]               r_cnt;
    logic signed [ALU_RW-1:0] r_res;
    logic [48:0]              r_rem;
    logic [48:0]              r_dsh;
    logic [DIV_STEPS-1:0]     r_q;
    logic                     r_neg;
    logic                     r_dz;
    logic [ALU_AW-1:0]        r_v;
    logic [ALU_AW-1:0]        r_r;
    logic [ALU_AW-1:0]        r_bit;

    logic signed [47:0]       w_num;
    logic [47:0]              w_mag;
    logic                     w_ge;
    logic [48:0]              n_rem;
    logic [DIV_STEPS-1:0]     n_q;
    logic signed [ALU_RW-1:0] w_qext;
    logic signed [ALU_RW-1:0] w_div_res;
    logic [ALU_AW-1:0]        w_t;
    logic                     w_sge;
    logic [ALU_AW-1:0]        n_v;
    logic [ALU_AW-1:0]        n_r;

    assign w_num     = $signed(i_a[47:0]);
    assign w_mag     = w_num[47] ? 48'(-w_num) : w_num;
    assign w_ge      = r_rem >= r_dsh;
    assign n_rem     = w_ge ? r_rem - r_dsh : r_rem;
    assign n_q       = {r_q[DIV_STEPS-2:0], w_ge};
    assign w_qext    = {{(ALU_RW-DIV_STEPS){1'b0}}, n_q};
    assign w_div_res = r_dz ? '0 : (r_neg ? -w_qext : w_qext);
    assign w_t       = r_r + r_bit;
    assign w_sge     = r_v >= w_t;
    assign n_v       = w_sge ? r_v - w_t : r_v;
    assign n_r       = w_sge ? (r_r >> 1) + r_bit : r_r >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op <= i_req.op;
                case (i_req.op)
                    ALU_MUL: begin
                        r_res  <= $signed(i_a[ALU_BW-1:0]) * i_b;
                        r_done <= 1'b1;
                    end
                    ALU_DIV: begin
                        r_rem  <= {1'b0, w_mag} + {18'b0, i_b[31:1]};
                        r_dsh  <= {i_b[31:0], 17'b0};
                        r_q    <= '0;
                        r_neg  <= w_num[47];
                        r_dz   <= (i_b[31:0] == 32'd0);
                        r_cnt  <= 5'(DIV_STEPS - 1);
                        r_busy <= 1'b1;
                    end
                    ALU_SQRT: begin
                        r_v    <= i_a;
                        r_r    <= '0;
                        r_bit  <= SQRT_BIT0;
                        r_cnt  <= 5'(SQRT_STEPS - 1);
                        r_busy <= 1'b1;
                    end
                    default: begin
                        r_res  <= '0;
                        r_done <= 1'b1;
                    end
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_op == ALU_DIV) begin
                    r_rem <= n_rem;
                    r_dsh <= r_dsh >> 1;
                    r_q   <= n_q;
                    if (r_cnt == 5'd0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_res  <= w_div_res;
                    end
                end else begin
                    r_v   <= n_v;
                    r_r   <= n_r;
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'd0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_res  <= {{(ALU_RW-ALU_AW){1'b0}}, n_r};
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_res      = r_res;

endmodule

>>> rtl/core/touch_stick_deadzone_tracker.sv
// Top level: touch stick tracker with sequencer, state and config registers.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | i_valid / o_stall    | i_event_kind, i_touch_id, i_pos_x/y
//   output   | o_valid / i_stall    | flags, o_held, o_dir_x/y, knob, centre
//   config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// A tracked event runs the shared unit's 28-step square root; once the input is active it
// also runs 18-step divisions for the direction, and two more when the offset is clamped.
// A return to rest runs two multiplies on the shared unit.
// Synchronous active-low reset restores the register defaults and the rest state.
// While an output beat is stalled one more event is taken; it then waits for the beat to go.
module touch_stick_deadzone_tracker import tsdt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_event_kind,
    input  logic [3:0]         i_touch_id,
    input  logic [15:0]        i_pos_x,
    input  logic [15:0]        i_pos_y,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_pressed_flag,
    output logic               o_released_flag,
    output logic               o_tapped_flag,
    output logic               o_flicked_flag,
    output logic               o_cancel_flag,
    output logic               o_held,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [17:0] o_knob_x,
    output logic signed [17:0] o_knob_y,
    output logic signed [17:0] o_center_x,
    output logic signed [17:0] o_center_y
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_REST0 = 5'd1;
    localparam logic [4:0] S_REST1 = 5'd2;
    localparam logic [4:0] S_REST2 = 5'd3;
    localparam logic [4:0] S_DISP  = 5'd4;
    localparam logic [4:0] S_TRK0  = 5'd5;
    localparam logic [4:0] S_TRK1  = 5'd6;
    localparam logic [4:0] S_TRK2  = 5'd7;
    localparam logic [4:0] S_TRK3  = 5'd8;
    localparam logic [4:0] S_TRK4  = 5'd9;
    localparam logic [4:0] S_TRK5  = 5'd10;
    localparam logic [4:0] S_TRK6  = 5'd11;
    localparam logic [4:0] S_TRK7  = 5'd12;
    localparam logic [4:0] S_TRK8  = 5'd13;
    localparam logic [4:0] S_TRK9  = 5'd14;
    localparam logic [4:0] S_TRK10 = 5'd15;
    localparam logic [4:0] S_TRK11 = 5'd16;
    localparam logic [4:0] S_TRK12 = 5'd17;
    localparam logic [4:0] S_TRK13 = 5'd18;
    localparam logic [4:0] S_TRK14 = 5'd19;
    localparam logic [4:0] S_TRK15 = 5'd20;
    localparam logic [4:0] S_TRK16 = 5'd21;
    localparam logic [4:0] S_TRK17 = 5'd22;
    localparam logic [4:0] S_TRK18 = 5'd23;
    localparam logic [4:0] S_CAN   = 5'd24;
    localparam logic [4:0] S_OUT   = 5'd25;

    logic [4:0]         r_state;
    logic [1:0]         r_mode;
    logic [12:0]        r_diam;
    logic [8:0]         r_dead;
    logic [9:0]         r_clamp;
    logic [8:0]         r_rrx;
    logic [8:0]         r_rry;
    logic [15:0]        r_aw;
    logic [15:0]        r_ah;
    logic               r_held;
    logic               r_own_v;
    logic [3:0]         r_own_id;
    logic               r_active;
    logic               r_moved;
    logic               r_cancel;
    logic               r_rest_pend;
    logic               r_disp_done;
    logic signed [17:0] r_base_x;
    logic signed [17:0] r_base_y;
    logic signed [17:0] r_tip_x;
    logic signed [17:0] r_tip_y;
    logic signed [15:0] r_dir_x;
    logic signed [15:0] r_dir_y;
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dy;
    logic [1:0]         r_kind;
    logic [3:0]         r_id;
    logic [15:0]        r_px;
    logic [15:0]        r_py;
    logic               r_f_press;
    logic               r_f_rel;
    logic               r_f_tap;
    logic               r_f_flick;
    logic               r_f_cancel;
    logic signed [18:0] r_off_x;
    logic signed [18:0] r_off_y;
    logic [35:0]        r_len2;
    logic [22:0]        r_rc;
    logic               r_clamped;
    logic [27:0]        r_l9;
    logic signed [18:0] r_cl_x;
    logic signed [18:0] r_cl_y;
    logic [31:0]        r_a17;
    logic [14:0]        r_s;
    logic               r_was;
    logic               r_has;
    logic               r_ovalid;

    t_alu_req                 w_req;
    t_alu_rsp                 w_rsp;
    logic [ALU_AW-1:0]        w_a;
    logic signed [ALU_BW-1:0] w_b;
    logic signed [ALU_RW-1:0] w_res;

    logic               w_in_area;
    logic               w_roam;
    logic               w_own_match;
    logic signed [20:0] w_px2;
    logic signed [20:0] w_py2;
    logic signed [20:0] w_bx2;
    logic signed [20:0] w_by2;
    logic signed [20:0] w_d;
    logic               w_in_sq;
    logic               w_follow;
    logic signed [19:0] w_nbase_x;
    logic signed [19:0] w_nbase_y;
    logic signed [19:0] w_tsum_x;
    logic signed [19:0] w_tsum_y;
    logic signed [17:0] w_tip_x;
    logic signed [17:0] w_tip_y;
    logic               w_has;
    logic [35:0]        w_lc;
    logic [30:0]        w_rc256;
    logic [31:0]        w_den;
    logic [35:0]        w_snum;
    logic               w_sdiv;
    logic signed [18:0] w_q;
    logic signed [15:0] w_qsat;
    logic [16:0]        w_rest;
    logic               w_geo_chg;

    assign w_in_area   = (r_px < r_aw) && (r_py < r_ah);
    assign w_roam      = (r_mode == MODE_DYNAMIC) || (r_mode == MODE_FOLLOW);
    assign w_own_match = r_own_v && (r_id == r_own_id);
    assign w_px2       = {4'b0, r_px, 1'b0};
    assign w_py2       = {4'b0, r_py, 1'b0};
    assign w_bx2       = {{2{r_base_x[17]}}, r_base_x, 1'b0};
    assign w_by2       = {{2{r_base_y[17]}}, r_base_y, 1'b0};
    assign w_d         = {8'b0, r_diam};
    assign w_in_sq     = (w_px2 >= w_bx2 - w_d) && (w_px2 < w_bx2 + w_d) &&
                         (w_py2 >= w_by2 - w_d) && (w_py2 < w_by2 + w_d);

    assign w_follow  = (r_mode == MODE_FOLLOW) && r_clamped && w_in_area;
    assign w_nbase_x = w_follow ? $signed({4'b0, r_px}) - {r_cl_x[18], r_cl_x}
                                : {{2{r_base_x[17]}}, r_base_x};
    assign w_nbase_y = w_follow ? $signed({4'b0, r_py}) - {r_cl_y[18], r_cl_y}
                                : {{2{r_base_y[17]}}, r_base_y};
    assign w_tsum_x  = w_nbase_x + {r_cl_x[18], r_cl_x};
    assign w_tsum_y  = w_nbase_y + {r_cl_y[18], r_cl_y};
    assign w_tip_x   = (w_tsum_x > 20'sd131071) ? 18'sd131071 :
                       (w_tsum_x < -20'sd131072) ? 18'sh20000 : w_tsum_x[17:0];
    assign w_tip_y   = (w_tsum_y > 20'sd131071) ? 18'sd131071 :
                       (w_tsum_y < -20'sd131072) ? 18'sh20000 : w_tsum_y[17:0];

    assign w_has   = r_clamped ? ((r_rc != 23'd0) && (r_dead < 9'd256))
                               : ({r_len2[29:0], 34'b0} > w_res[63:0]);
    assign w_lc    = r_clamped ? {5'b0, r_rc, 8'b0} : {r_l9, 8'b0};
    assign w_rc256 = {r_rc, 8'b0};
    assign w_den   = ({1'b0, w_rc256} > r_a17) ? {1'b0, w_rc256} - r_a17 : 32'd0;
    assign w_snum  = w_lc - {4'b0, r_a17};
    assign w_sdiv  = w_has && (w_lc > {4'b0, r_a17}) && (w_den != 32'd0);

    assign w_q    = w_res[18:0];
    assign w_qsat = (w_q > 19'sd16384) ? 16'sd16384 :
                    (w_q < -19'sd16384) ? -16'sd16384 : w_q[15:0];
    assign w_rest = 17'((w_res[24:0] + 25'd128) >> 8);

    always_comb begin
        w_geo_chg = 1'b0;
        case (i_cfg_idx)
            CFG_DIAM:   w_geo_chg = (i_cfg_data[12:0] != r_diam);
            CFG_REST_X: w_geo_chg = (i_cfg_data[8:0] != r_rrx);
            CFG_REST_Y: w_geo_chg = (i_cfg_data[8:0] != r_rry);
            CFG_AREA_W: w_geo_chg = (i_cfg_data != r_aw);
            CFG_AREA_H: w_geo_chg = (i_cfg_data != r_ah);
            default:    w_geo_chg = 1'b0;
        endcase
    end

    always_comb begin
        w_req = '0;
        w_a   = '0;
        w_b   = '0;
        case (r_state)
            S_REST0: begin
                w_req = '{start: 1'b1, op: ALU_MUL};
                w_a   = {40'b0, r_aw};
                w_b   = {25'b0, r_rrx};
            end
            S_REST1: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {40'b0, r_ah};
                w_b   = {25'b0, r_rry};
            end
            S_TRK1: begin
                w_req = '{start: 1'b1, op: ALU_MUL};
                w_a   = {{37{r_off_x[18]}}, r_off_x};
                w_b   = {{15{r_off_x[18]}}, r_off_x};
            end
            S_TRK2: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {{37{r_off_y[18]}}, r_off_y};
                w_b   = {{15{r_off_y[18]}}, r_off_y};
            end
            S_TRK3: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {43'b0, r_diam};
                w_b   = {24'b0, r_clamp};
            end
            S_TRK4: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {33'b0, w_res[22:0]};
                w_b   = {11'b0, w_res[22:0]};
            end
            S_TRK5: begin
                w_req = '{start: w_rsp.done, op: ALU_SQRT};
                w_a   = {2'b0, r_len2, 18'b0};
            end
            S_TRK6: begin
                w_req = '{start: w_rsp.done && r_clamped, op: ALU_MUL};
                w_a   = {{37{r_off_x[18]}}, r_off_x};
                w_b   = {11'b0, r_rc};
            end
            S_TRK7, S_TRK9: begin
                w_req = '{start: w_rsp.done, op: ALU_DIV};
                w_a   = {{8{w_res[47]}}, w_res[47:0]};
                w_b   = {6'b0, r_l9};
            end
            S_TRK8: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {{37{r_off_y[18]}}, r_off_y};
                w_b   = {11'b0, r_rc};
            end
            S_TRK11: begin
                w_req = '{start: 1'b1, op: ALU_MUL};
                w_a   = {33'b0, r_rc};
                w_b   = {25'b0, r_dead};
            end
            S_TRK12: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {24'b0, w_res[31:0]};
                w_b   = {2'b0, w_res[31:0]};
            end
            S_TRK13: begin
                w_req = '{start: w_rsp.done && w_sdiv, op: ALU_DIV};
                w_a   = {8'b0, w_snum[33:0], 14'b0};
                w_b   = {2'b0, w_den};
            end
            S_TRK14: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {{37{r_off_x[18]}}, r_off_x};
                w_b   = {15'b0, w_res[18:0]};
            end
            S_TRK15, S_TRK17: begin
                w_req = '{start: w_rsp.done, op: ALU_DIV};
                w_a   = {{8{w_res[38]}}, w_res[38:0], 9'b0};
                w_b   = {6'b0, r_l9};
            end
            S_TRK16: begin
                w_req = '{start: w_rsp.done, op: ALU_MUL};
                w_a   = {{37{r_off_y[18]}}, r_off_y};
                w_b   = {19'b0, r_s};
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    tsdt_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 2'd0;
            r_diam      <= 13'd1600;
            r_dead      <= 9'd0;
            r_clamp     <= 10'd256;
            r_rrx       <= 9'd128;
            r_rry       <= 9'd128;
            r_aw        <= 16'd16384;
            r_ah        <= 16'd16384;
            r_held      <= 1'b0;
            r_own_v     <= 1'b0;
            r_own_id    <= 4'd0;
            r_active    <= 1'b0;
            r_moved     <= 1'b0;
            r_cancel    <= 1'b0;
            r_dir_x     <= '0;
            r_dir_y     <= '0;
            r_rest_pend <= 1'b1;
            r_disp_done <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind      <= i_event_kind;
                        r_id        <= i_touch_id;
                        r_px        <= i_pos_x;
                        r_py        <= i_pos_y;
                        r_f_press   <= 1'b0;
                        r_f_rel     <= 1'b0;
                        r_f_tap     <= 1'b0;
                        r_f_flick   <= 1'b0;
                        r_f_cancel  <= 1'b0;
                        r_disp_done <= 1'b0;
                        r_state     <= r_rest_pend ? S_REST0 : S_DISP;
                    end
                end
                S_REST0: begin
                    r_state <= S_REST1;
                end
                S_REST1: begin
                    if (w_rsp.done) begin
                        r_base_x <= {1'b0, w_rest};
                        r_tip_x  <= {1'b0, w_rest};
                        r_state  <= S_REST2;
                    end
                end
                S_REST2: begin
                    if (w_rsp.done) begin
                        r_base_y    <= {1'b0, w_rest};
                        r_tip_y     <= {1'b0, w_rest};
                        r_rest_pend <= 1'b0;
                        r_state     <= r_disp_done ? S_OUT : S_DISP;
                    end
                end
                S_DISP: begin
                    r_dx    <= r_dir_x;
                    r_dy    <= r_dir_y;
                    r_state <= S_OUT;
                    case (r_kind)
                        EV_PRESS: begin
                            if (!r_own_v && w_in_area && (w_roam || w_in_sq)) begin
                                if (w_roam) begin
                                    r_base_x <= {2'b0, r_px};
                                    r_base_y <= {2'b0, r_py};
                                end
                                r_f_press <= 1'b1;
                                r_held    <= 1'b1;
                                r_own_v   <= 1'b1;
                                r_own_id  <= r_id;
                                r_state   <= S_TRK0;
                            end
                        end
                        EV_RELEASE: begin
                            if (w_own_match) begin
                                r_f_rel     <= 1'b1;
                                r_f_tap     <= !r_cancel && !r_moved;
                                r_f_flick   <= (r_cancel || r_moved) && r_active && r_moved;
                                r_held      <= 1'b0;
                                r_own_v     <= 1'b0;
                                r_own_id    <= 4'd0;
                                r_active    <= 1'b0;
                                r_moved     <= 1'b0;
                                r_cancel    <= 1'b0;
                                r_dir_x     <= '0;
                                r_dir_y     <= '0;
                                r_rest_pend <= 1'b1;
                                r_disp_done <= 1'b1;
                                r_state     <= S_REST0;
                            end
                        end
                        EV_DRAG: begin
                            if (w_own_match) begin
                                r_moved <= 1'b1;
                                r_state <= S_TRK0;
                            end
                        end
                        default: begin
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_TRK0: begin
                    r_off_x <= $signed({3'b0, r_px}) - {r_base_x[17], r_base_x};
                    r_off_y <= $signed({3'b0, r_py}) - {r_base_y[17], r_base_y};
                    r_state <= S_TRK1;
                end
                S_TRK1: begin
                    r_state <= S_TRK2;
                end
                S_TRK2: begin
                    if (w_rsp.done) begin
                        r_len2  <= w_res[35:0];
                        r_state <= S_TRK3;
                    end
                end
                S_TRK3: begin
                    if (w_rsp.done) begin
                        r_len2  <= r_len2 + w_res[35:0];
                        r_state <= S_TRK4;
                    end
                end
                S_TRK4: begin
                    if (w_rsp.done) begin
                        r_rc    <= w_res[22:0];
                        r_state <= S_TRK5;
                    end
                end
                S_TRK5: begin
                    if (w_rsp.done) begin
                        r_clamped <= {r_len2, 18'b0} > w_res[53:0];
                        r_state   <= S_TRK6;
                    end
                end
                S_TRK6: begin
                    if (w_rsp.done) begin
                        r_l9 <= w_res[27:0];
                        if (r_clamped) begin
                            r_state <= S_TRK7;
                        end else begin
                            r_cl_x  <= r_off_x;
                            r_cl_y  <= r_off_y;
                            r_state <= S_TRK11;
                        end
                    end
                end
                S_TRK7: begin
                    if (w_rsp.done) begin
                        r_state <= S_TRK8;
                    end
                end
                S_TRK8: begin
                    if (w_rsp.done) begin
                        r_cl_x  <= w_q;
                        r_state <= S_TRK9;
                    end
                end
                S_TRK9: begin
                    if (w_rsp.done) begin
                        r_state <= S_TRK10;
                    end
                end
                S_TRK10: begin
                    if (w_rsp.done) begin
                        r_cl_y  <= w_q;
                        r_state <= S_TRK11;
                    end
                end
                S_TRK11: begin
                    r_base_x <= w_nbase_x[17:0];
                    r_base_y <= w_nbase_y[17:0];
                    r_tip_x  <= w_tip_x;
                    r_tip_y  <= w_tip_y;
                    r_state  <= S_TRK12;
                end
                S_TRK12: begin
                    if (w_rsp.done) begin
                        r_a17   <= w_res[31:0];
                        r_state <= S_TRK13;
                    end
                end
                S_TRK13: begin
                    if (w_rsp.done) begin
                        r_was    <= r_active;
                        r_has    <= w_has;
                        r_active <= w_has;
                        if (w_sdiv) begin
                            r_state <= S_TRK14;
                        end else begin
                            r_dir_x <= '0;
                            r_dir_y <= '0;
                            r_state <= S_CAN;
                        end
                    end
                end
                S_TRK14: begin
                    if (w_rsp.done) begin
                        r_s     <= w_res[14:0];
                        r_state <= S_TRK15;
                    end
                end
                S_TRK15: begin
                    if (w_rsp.done) begin
                        r_state <= S_TRK16;
                    end
                end
                S_TRK16: begin
                    if (w_rsp.done) begin
                        r_dir_x <= w_qsat;
                        r_state <= S_TRK17;
                    end
                end
                S_TRK17: begin
                    if (w_rsp.done) begin
                        r_state <= S_TRK18;
                    end
                end
                S_TRK18: begin
                    if (w_rsp.done) begin
                        r_dir_y <= w_qsat;
                        r_state <= S_CAN;
                    end
                end
                S_CAN: begin
                    if (!r_cancel && r_was && !r_has) begin
                        r_cancel   <= 1'b1;
                        r_f_cancel <= 1'b1;
                    end else if (r_cancel && !r_was && r_has) begin
                        r_cancel <= 1'b0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        o_pressed_flag  <= r_f_press;
                        o_released_flag <= r_f_rel;
                        o_tapped_flag   <= r_f_tap;
                        o_flicked_flag  <= r_f_flick;
                        o_cancel_flag   <= r_f_cancel;
                        o_held          <= r_held;
                        o_dir_x         <= (r_kind == EV_RELEASE) ? r_dx : r_dir_x;
                        o_dir_y         <= (r_kind == EV_RELEASE) ? r_dy : r_dir_y;
                        o_knob_x        <= r_tip_x;
                        o_knob_y        <= r_tip_y;
                        o_center_x      <= r_base_x;
                        o_center_y      <= r_base_y;
                        r_ovalid        <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:   r_mode  <= i_cfg_data[1:0];
                    CFG_DIAM:   r_diam  <= i_cfg_data[12:0];
                    CFG_DEAD:   r_dead  <= i_cfg_data[8:0];
                    CFG_CLAMP:  r_clamp <= i_cfg_data[9:0];
                    CFG_REST_X: r_rrx   <= i_cfg_data[8:0];
                    CFG_REST_Y: r_rry   <= i_cfg_data[8:0];
                    CFG_AREA_W: r_aw    <= i_cfg_data;
                    CFG_AREA_H: r_ah    <= i_cfg_data;
                    default: begin
                    end
                endcase
                if (w_geo_chg) begin
                    r_held      <= 1'b0;
                    r_own_v     <= 1'b0;
                    r_own_id    <= 4'd0;
                    r_active    <= 1'b0;
                    r_moved     <= 1'b0;
                    r_cancel    <= 1'b0;
                    r_dir_x     <= '0;
                    r_dir_y     <= '0;
                    r_rest_pend <= 1'b1;
                end
            end
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;

endmodule
